// ===== hw/rtl/supq_pkg.sv =====
// Shared types and codes for the sorted unique priority queue.
package supq_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_POP      = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Update applied by every cell in the execute cycle
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INS  = 2'd1,
    SH_DEL  = 2'd2,
    SH_POP  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/supq_cell.sv =====
// One cell of the sorted key chain: holds a key, compares and shifts with its neighbours.
module supq_cell
  import supq_pkg::*;
#(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic                 valid,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic                 left_lt,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0] key,
  output logic                 lt,
  output logic                 eq
);

  // Compare the held key with the broadcast key, then shift or load it
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt <= valid && ($signed(key) < $signed(new_key));
      eq <= valid && (key == new_key);
    end
    case (ctl.op)
      SH_INS: begin
        if (!lt) begin
          key <= left_lt ? new_key : left_key;
        end
      end
      SH_DEL: begin
        if (!lt) begin
          key <= right_key;
        end
      end
      SH_POP: begin
        key <= right_key;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_unique_priority_queue_top.sv =====
// Each command item passes a compare state in every cell of the chain, then an execute
// state that shifts the chain and writes the result register. A new item is accepted only
// when idle or as the execute state completes; a result still held at the output keeps
// the chain in its execute state and stalls the input.
// Reset clears the key count, the control state and the output valid; the keys held
// in the cells are not cleared and are never read above the count.
module sorted_unique_priority_queue_top
  import supq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // command [1:0], key [KEY_WIDTH+1:2], zero pad above
  input  logic [((CMD_W+KEY_WIDTH+7)/8)*8-1:0]        s_tdata,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // status [1:0], found [2], popped_key [KEY_WIDTH+2:3], occupancy [KEY_WIDTH+7:KEY_WIDTH+3]
  output logic [((STATUS_W+1+KEY_WIDTH+OCC_W+7)/8)*8-1:0] m_tdata
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((STATUS_W + 1 + KEY_WIDTH + OCC_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t               state;
  cmd_t                 op_cmd;
  logic [KEY_WIDTH-1:0] op_key;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  status_t              out_status;
  logic                 out_found;
  logic [KEY_WIDTH-1:0] out_popped;
  logic [OCC_W-1:0]     out_occ;

  status_t              res_status;
  logic                 res_found;
  logic [KEY_WIDTH-1:0] res_popped;
  cell_op_t             res_op;

  logic                 out_free;
  logic                 done;
  logic                 hit;
  logic                 full;
  logic                 empty;
  cell_ctl_t            ctl;

  logic [KEY_WIDTH-1:0] key_arr [CAPACITY];
  logic [CAPACITY-1:0]  lt_vec;
  logic [CAPACITY-1:0]  eq_vec;

  // Handshake: accept when idle, or when the current item completes this cycle
  assign out_free = !m_tvalid || m_tready;
  assign done     = (state == S_EXEC) && out_free;
  assign s_tready = (state == S_IDLE) || done;

  assign hit   = |eq_vec;
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // Decide status, found and chain update from the compare flags
  always_comb begin
    res_status = ST_DONE;
    res_found  = 1'b0;
    res_popped = '0;
    res_op     = SH_HOLD;
    count_next = count;
    unique case (op_cmd)
      CMD_INSERT: begin
        if (hit) begin
          res_status = ST_NOCHANGE;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_op     = SH_INS;
          count_next = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          res_op     = SH_DEL;
          count_next = count - CW'(1);
        end else begin
          res_status = ST_NOCHANGE;
        end
      end
      CMD_CONTAINS: begin
        if (hit) begin
          res_found = 1'b1;
        end else begin
          res_status = ST_NOCHANGE;
        end
      end
      CMD_POP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_found  = 1'b1;
          res_popped = key_arr[0];
          res_op     = SH_POP;
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Drive the cells
  always_comb begin
    ctl.cmp_en = (state == S_CMP);
    ctl.op     = done ? res_op : SH_HOLD;
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [KEY_WIDTH-1:0] left_key;
    logic [KEY_WIDTH-1:0] right_key;
    logic                 left_lt;

    if (i == 0) begin : g_head
      assign left_key = op_key;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_key = key_arr[i-1];
      assign left_lt  = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = key_arr[i];
    end else begin : g_inner
      assign right_key = key_arr[i+1];
    end

    supq_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (IDX < count),
      .new_key  (op_key),
      .left_key (left_key),
      .left_lt  (left_lt),
      .right_key(right_key),
      .key      (key_arr[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i])
    );
  end

  // Hold state, count, command and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (done) begin
            count      <= count_next;
            out_status <= res_status;
            out_found  <= res_found;
            out_popped <= res_popped;
            out_occ    <= OCC_W'(count_next);
            state      <= s_tvalid ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (s_tvalid && s_tready) begin
      op_cmd <= cmd_t'(s_tdata[CMD_W-1:0]);
      op_key <= s_tdata[CMD_W+KEY_WIDTH-1:CMD_W];
    end
  end

  assign m_tdata = OUT_W'({out_occ, out_popped, out_found, out_status});

`ifndef NO_ASSERTIONS
  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("key count above capacity");

  // No item is taken while the cells compare
  a_no_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> !s_tready)
    else $error("item accepted during compare");

  // Keys stay sorted: the less-than flags form a run from cell zero
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> (((lt_vec >> 1) & ~lt_vec) == '0))
    else $error("cell chain out of order");

  // An insert that shifts the chain adds exactly one key
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (done && res_op == SH_INS) |=> count == $past(count) + CW'(1))
    else $error("insert count mismatch");

  // An empty pop never reports a key
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_EMPTY) |-> !out_found)
    else $error("empty pop flagged as found");
`endif

endmodule
